### design/mdt_pkg.sv
package mdt_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int REQ_W           = 2;
    localparam int ADDR_W          = 48;
    localparam int RAW_PROF_W      = 8;
    localparam int PROF_W          = 2;
    localparam int TIME_W          = 32;
    localparam int ENTRY_W         = 5;

    // Largest profile code a set request may store
    localparam logic [PROF_W-1:0] PROFILE_MAX = 2'd3;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        OP_TOUCH  = 2'd0,
        OP_SET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    // Classified request as it travels from the front end to the table
    typedef struct packed {
        op_t                 op;
        logic [ADDR_W-1:0]   addr;
        logic [PROF_W-1:0]   profile;
        logic [TIME_W-1:0]   now;
    } mdt_req_t;

    // Head of the request queue as seen by the table
    typedef struct packed {
        logic     valid;
        mdt_req_t req;
    } mdt_head_t;

    // One result beat
    typedef struct packed {
        logic                status;
        logic                found;
        logic [PROF_W-1:0]   profile;
        logic [TIME_W-1:0]   last_seen;
        logic [ENTRY_W-1:0]  entry_count;
        logic                evicted;
        logic                changed;
    } mdt_res_t;

    // Table sequencer: search the cells, then update them
    typedef enum logic {
        BK_MATCH = 1'b0,
        BK_APPLY = 1'b1
    } back_state_t;

endpackage

### design/mdt_if.sv
interface mdt_req_if import mdt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [REQ_W-1:0]       req_type;
    logic [ADDR_W-1:0]      device_address;
    logic [RAW_PROF_W-1:0]  profile_value;
    logic [TIME_W-1:0]      now_ms;

    modport source (
        output valid, req_type, device_address, profile_value, now_ms,
        input  ready
    );
    modport sink (
        input  valid, req_type, device_address, profile_value, now_ms,
        output ready
    );
endinterface

interface mdt_resp_if import mdt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 status;
    logic                 found;
    logic [PROF_W-1:0]    profile_out;
    logic [TIME_W-1:0]    last_seen_out;
    logic [ENTRY_W-1:0]   entry_count;
    logic                 evicted;
    logic                 changed;

    modport source (
        output valid, status, found, profile_out, last_seen_out, entry_count,
               evicted, changed,
        input  ready
    );
    modport sink (
        input  valid, status, found, profile_out, last_seen_out, entry_count,
               evicted, changed,
        output ready
    );
endinterface

### design/mdt_front.sv
module mdt_front import mdt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    mdt_req_if.sink   req,
    output logic      push,
    output mdt_req_t  push_data,
    input  logic      q_full
);

    logic     stage_valid_reg;
    logic     stage_valid_next;
    mdt_req_t stage_reg;
    mdt_req_t stage_next;
    logic     take;
    op_t      op;

    // Stage is free when empty or draining into the queue this cycle
    assign req.ready = !stage_valid_reg || !q_full;
    assign take      = req.valid && req.ready;
    assign push      = stage_valid_reg && !q_full;
    assign push_data = stage_reg;

    // Decode and clamp; only a set request carries a profile
    always_comb
    begin
        op                 = op_t'(req.req_type);
        stage_next.op      = op;
        stage_next.addr    = req.device_address;
        stage_next.now     = req.now_ms;
        stage_next.profile = '0;
        if (op == OP_SET)
        begin
            if (req.profile_value > RAW_PROF_W'(PROFILE_MAX))
                stage_next.profile = PROFILE_MAX;
            else
                stage_next.profile = req.profile_value[PROF_W-1:0];
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
            stage_valid_next = 1'b1;
        else if (push)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            stage_reg <= stage_next;
    end

endmodule

### design/mdt_queue.sv
module mdt_queue import mdt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  mdt_req_t   push_data,
    output logic       full,
    input  logic       pop,
    output mdt_head_t  head
);

    // Two-entry queue between front end and table
    mdt_req_t    mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.req   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### design/mdt_table.sv
module mdt_table import mdt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  mdt_head_t   head,
    output logic        pop,
    mdt_resp_if.source  resp
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Cell array, slot 0 is the most recent entry
    logic [ADDR_W-1:0] addr_reg  [TABLE_DEPTH];
    logic [ADDR_W-1:0] addr_next [TABLE_DEPTH];
    logic [PROF_W-1:0] prof_reg  [TABLE_DEPTH];
    logic [PROF_W-1:0] prof_next [TABLE_DEPTH];
    logic [TIME_W-1:0] time_reg  [TABLE_DEPTH];
    logic [TIME_W-1:0] time_next [TABLE_DEPTH];

    // Neighbor taps for shifting toward the tail or the head
    logic [ADDR_W-1:0] left_addr  [TABLE_DEPTH];
    logic [PROF_W-1:0] left_prof  [TABLE_DEPTH];
    logic [TIME_W-1:0] left_time  [TABLE_DEPTH];
    logic [ADDR_W-1:0] right_addr [TABLE_DEPTH];
    logic [PROF_W-1:0] right_prof [TABLE_DEPTH];
    logic [TIME_W-1:0] right_time [TABLE_DEPTH];

    logic              enable_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    back_state_t       state_reg;
    back_state_t       state_next;

    // Search results held for the update cycle
    mdt_req_t                cur_reg;
    logic [TABLE_DEPTH-1:0]  hit_reg;
    logic [TABLE_DEPTH-1:0]  pre_reg;
    logic                    found_reg;
    logic [PROF_W-1:0]       hit_prof_reg;
    logic [TIME_W-1:0]       hit_time_reg;

    logic [TABLE_DEPTH-1:0]  hit_vec;
    logic [TABLE_DEPTH-1:0]  pre_vec;
    logic [PROF_W-1:0]       hit_prof;
    logic [TIME_W-1:0]       hit_time;

    mdt_res_t  res_reg;
    mdt_res_t  res_next;
    logic      res_valid_reg;
    logic      res_valid_next;

    logic apply_fire;
    logic do_ins;
    logic do_front;
    logic do_set;
    logic do_rem;
    logic is_full;

    // Compare every live cell against the queue head
    always_comb
    begin
        hit_prof = '0;
        hit_time = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit_vec[i] = (CNT_W'(i) < count_reg) && (addr_reg[i] == head.req.addr);
            if (hit_vec[i])
            begin
                hit_prof = hit_prof | prof_reg[i];
                hit_time = hit_time | time_reg[i];
            end
        end
    end

    // pre_vec marks cells beyond the hit (a hit lies in a lower slot)
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_pre
        if (i == 0)
        begin : g_first
            assign pre_vec[i] = 1'b0;
        end
        else
        begin : g_rest
            assign pre_vec[i] = |hit_vec[i-1:0];
        end
    end

    // Neighbor wiring; edge cells see themselves
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_tap
        if (i == 0)
        begin : g_left_edge
            assign left_addr[i] = addr_reg[i];
            assign left_prof[i] = prof_reg[i];
            assign left_time[i] = time_reg[i];
        end
        else
        begin : g_left
            assign left_addr[i] = addr_reg[i-1];
            assign left_prof[i] = prof_reg[i-1];
            assign left_time[i] = time_reg[i-1];
        end
        if (i == TABLE_DEPTH - 1)
        begin : g_right_edge
            assign right_addr[i] = addr_reg[i];
            assign right_prof[i] = prof_reg[i];
            assign right_time[i] = time_reg[i];
        end
        else
        begin : g_right
            assign right_addr[i] = addr_reg[i+1];
            assign right_prof[i] = prof_reg[i+1];
            assign right_time[i] = time_reg[i+1];
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_MATCH:
            begin
                if (head.valid)
                    state_next = BK_APPLY;
            end
            BK_APPLY:
            begin
                if (apply_fire)
                    state_next = BK_MATCH;
            end
            default:
            begin
                state_next = BK_MATCH;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pop        = 1'b0;
        apply_fire = 1'b0;
        unique case (state_reg)
            BK_MATCH:
            begin
                pop = head.valid;
            end
            BK_APPLY:
            begin
                apply_fire = !res_valid_reg || resp.ready;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Decode the update
    assign is_full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign do_ins   = enable_reg && !found_reg
                      && (cur_reg.op == OP_TOUCH || cur_reg.op == OP_SET);
    assign do_front = enable_reg && found_reg && (cur_reg.op == OP_TOUCH);
    assign do_set   = enable_reg && found_reg && (cur_reg.op == OP_SET);
    assign do_rem   = enable_reg && found_reg && (cur_reg.op == OP_REMOVE);

    // Per-cell next value: new head, shift down, shift up or profile write
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            addr_next[i] = addr_reg[i];
            prof_next[i] = prof_reg[i];
            time_next[i] = time_reg[i];
            if (apply_fire)
            begin
                if ((do_ins || do_front) && i == 0)
                begin
                    addr_next[i] = cur_reg.addr;
                    prof_next[i] = do_ins ? cur_reg.profile : hit_prof_reg;
                    time_next[i] = cur_reg.now;
                end
                else if (do_ins || (do_front && !pre_reg[i]))
                begin
                    addr_next[i] = left_addr[i];
                    prof_next[i] = left_prof[i];
                    time_next[i] = left_time[i];
                end
                else if (do_set && hit_reg[i])
                begin
                    prof_next[i] = cur_reg.profile;
                end
                else if (do_rem && (pre_reg[i] || hit_reg[i]))
                begin
                    addr_next[i] = right_addr[i];
                    prof_next[i] = right_prof[i];
                    time_next[i] = right_time[i];
                end
            end
        end
    end

    // Count and result beat
    always_comb
    begin
        count_next = count_reg;
        if (apply_fire && do_ins && !is_full)
            count_next = count_reg + CNT_W'(1);
        else if (apply_fire && do_rem)
            count_next = count_reg - CNT_W'(1);

        res_next.status      = !enable_reg;
        res_next.found       = enable_reg && found_reg;
        res_next.profile     = '0;
        res_next.last_seen   = '0;
        res_next.entry_count = ENTRY_W'(count_next);
        res_next.evicted     = do_ins && is_full;
        res_next.changed     = do_ins || do_front || do_set || do_rem;
        if (enable_reg)
        begin
            unique case (cur_reg.op)
                OP_TOUCH:
                begin
                    res_next.profile   = found_reg ? hit_prof_reg : cur_reg.profile;
                    res_next.last_seen = cur_reg.now;
                end
                OP_SET:
                begin
                    res_next.profile   = cur_reg.profile;
                    res_next.last_seen = found_reg ? hit_time_reg : cur_reg.now;
                end
                OP_REMOVE:
                begin
                    res_next.profile   = '0;
                    res_next.last_seen = '0;
                end
                OP_LOOKUP:
                begin
                    res_next.profile   = found_reg ? hit_prof_reg : '0;
                    res_next.last_seen = found_reg ? hit_time_reg : '0;
                end
                default:
                begin
                    res_next.profile   = '0;
                    res_next.last_seen = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (apply_fire)
            res_valid_next = 1'b1;
        else if (resp.ready)
            res_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            count_reg     <= '0;
            state_reg     <= BK_MATCH;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                enable_reg <= cfg_wdata;
            count_reg     <= count_next;
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Search capture and result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg      <= head.req;
            hit_reg      <= hit_vec;
            pre_reg      <= pre_vec;
            found_reg    <= |hit_vec;
            hit_prof_reg <= hit_prof;
            hit_time_reg <= hit_time;
        end
        if (apply_fire)
            res_reg <= res_next;
    end

    // Cell storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            addr_reg[i] <= addr_next[i];
            prof_reg[i] <= prof_next[i];
            time_reg[i] <= time_next[i];
        end
    end

    assign resp.valid         = res_valid_reg;
    assign resp.status        = res_reg.status;
    assign resp.found         = res_reg.found;
    assign resp.profile_out   = res_reg.profile;
    assign resp.last_seen_out = res_reg.last_seen;
    assign resp.entry_count   = res_reg.entry_count;
    assign resp.evicted       = res_reg.evicted;
    assign resp.changed       = res_reg.changed;

endmodule

### design/mru_device_table.sv
// Recency-ordered table of 48-bit device addresses with profile and last-seen time.
// Request channel (req): one beat per request - touch, set profile, remove or
// lookup - with address, raw profile and current time. Response channel (resp):
// exactly one beat per request, in request order.
// Configuration: cfg_we/cfg_wdata write the table enable bit; change it only
// while no request is in flight. With the enable low every request is answered
// with a rejected status and the table is left alone.
// Path: a request beat, once taken, passes the input stage, the queue, the cell
// search and the cell update into the output register, which drives resp.
// The table sequencer takes one request at a time, searching all cells in its match
// state and shifting/updating them in its apply state, which waits on a resp stall.
// A two-entry queue plus the input stage let up to three requests wait.
// Reset: the table comes up empty and disabled; no clearing pass is needed.
// When resp is stalled the finished beat is held in the output register; the
// front end keeps taking requests until its stage and the queue are full.
module mru_device_table import mdt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mdt_req_if.sink     req,
    mdt_resp_if.source  resp,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    logic      push;
    mdt_req_t  push_data;
    logic      q_full;
    logic      pop;
    mdt_head_t head;

    mdt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    mdt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    mdt_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .pop       (pop),
        .resp      (resp)
    );

    // A rejected request never reports a hit or a table change
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid && resp.status |-> !resp.found && !resp.changed && !resp.evicted)
        else $error("rejected request reported table activity");

    // Eviction only happens on an insert of a new address
    a_evict_insert: assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid && resp.evicted |-> !resp.found && resp.changed && !resp.status)
        else $error("eviction without insert");

    // After an eviction the table stays full
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid && resp.evicted |-> resp.entry_count == ENTRY_W'(TABLE_DEPTH))
        else $error("eviction left table below capacity");

    // The queue is never popped while empty
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("request queue popped while empty");

endmodule

### tb/tb_mru_device_table.sv
`timescale 1ns / 1ps

module tb_mru_device_table;
    import mdt_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 200000;
    localparam int POOL_SIZE    = 24;
    localparam int HOLD_OFF_LEN = 80;
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    mdt_req_if  req_if ();
    mdt_resp_if resp_if ();

    mru_device_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .resp      (resp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted table: valid entries always sit in slots 0..count-1
    logic                pred_enable;
    logic [ADDR_W-1:0]   pred_addr [DEPTH];
    logic [PROF_W-1:0]   pred_prof [DEPTH];
    logic [TIME_W-1:0]   pred_seen [DEPTH];
    int                  pred_count;

    mdt_res_t            expected_responses [$];
    logic [ADDR_W-1:0]   addr_pool [POOL_SIZE];

    int  errors;
    int  requests_sent;
    int  responses_checked;
    int  evictions_seen;
    int  rejects_seen;
    int  cycle_count;
    bit  no_idle;
    int  hold_off_seq;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES)
            begin
                $display("%0t timeout after %0d cycles, %0d responses outstanding",
                         $time, cycle_count, expected_responses.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Insert at the front, dropping the tail when full; returns the eviction flag
    function automatic logic insert_at_front(logic [ADDR_W-1:0] addr,
                                             logic [PROF_W-1:0] prof,
                                             logic [TIME_W-1:0] now);
        int  keep;
        int  i;
        logic ev;
        keep = pred_count;
        ev   = 1'b0;
        if (keep >= DEPTH)
        begin
            keep = DEPTH - 1;
            ev   = 1'b1;
        end
        for (i = keep; i > 0; i--)
        begin
            pred_addr[i] = pred_addr[i-1];
            pred_prof[i] = pred_prof[i-1];
            pred_seen[i] = pred_seen[i-1];
        end
        pred_addr[0] = addr;
        pred_prof[0] = prof;
        pred_seen[0] = now;
        pred_count   = keep + 1;
        return ev;
    endfunction

    // Predicted response for one request; updates the predicted table
    function automatic mdt_res_t predict_response(op_t op, logic [ADDR_W-1:0] addr,
                                                  logic [RAW_PROF_W-1:0] raw,
                                                  logic [TIME_W-1:0] now);
        mdt_res_t          r;
        int                idx;
        int                i;
        int                at;
        logic [PROF_W-1:0] p;
        logic [ADDR_W-1:0] a;
        logic [PROF_W-1:0] ap;
        logic [TIME_W-1:0] at_seen;
        r   = '0;
        idx = -1;
        if (!pred_enable)
        begin
            r.status      = 1'b1;
            r.entry_count = pred_count[ENTRY_W-1:0];
            return r;
        end
        for (i = 0; i < pred_count; i++)
            if (idx < 0 && pred_addr[i] == addr)
                idx = i;
        r.found = (idx >= 0);
        case (op)
            OP_TOUCH:
            begin
                if (idx >= 0)
                begin
                    // refresh time, rotate entry to the head
                    a       = pred_addr[idx];
                    ap      = pred_prof[idx];
                    at_seen = now;
                    for (i = idx; i > 0; i--)
                    begin
                        pred_addr[i] = pred_addr[i-1];
                        pred_prof[i] = pred_prof[i-1];
                        pred_seen[i] = pred_seen[i-1];
                    end
                    pred_addr[0] = a;
                    pred_prof[0] = ap;
                    pred_seen[0] = at_seen;
                end
                else
                    r.evicted = insert_at_front(addr, '0, now);
                r.profile   = pred_prof[0];
                r.last_seen = pred_seen[0];
                r.changed   = 1'b1;
            end
            OP_SET:
            begin
                p = (raw > {{(RAW_PROF_W-PROF_W){1'b0}}, PROFILE_MAX}) ?
                    PROFILE_MAX : raw[PROF_W-1:0];
                if (idx >= 0)
                begin
                    at = idx;
                    pred_prof[at] = p;
                end
                else
                begin
                    r.evicted = insert_at_front(addr, p, now);
                    at = 0;
                end
                r.profile   = pred_prof[at];
                r.last_seen = pred_seen[at];
                r.changed   = 1'b1;
            end
            OP_REMOVE:
            begin
                if (idx >= 0)
                begin
                    // close the gap
                    for (i = idx; i + 1 < pred_count; i++)
                    begin
                        pred_addr[i] = pred_addr[i+1];
                        pred_prof[i] = pred_prof[i+1];
                        pred_seen[i] = pred_seen[i+1];
                    end
                    pred_count--;
                    r.changed = 1'b1;
                end
            end
            default:
            begin
                if (idx >= 0)
                begin
                    r.profile   = pred_prof[idx];
                    r.last_seen = pred_seen[idx];
                end
            end
        endcase
        r.entry_count = pred_count[ENTRY_W-1:0];
        return r;
    endfunction

    // Send one request beat; valid stays high on return
    task automatic send_request(op_t op, logic [ADDR_W-1:0] addr,
                                logic [RAW_PROF_W-1:0] raw, logic [TIME_W-1:0] now);
        mdt_res_t exp_res;
        if (!no_idle)
        begin
            while ($urandom_range(99) < 8)
            begin
                req_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_if.valid          <= 1'b1;
        req_if.req_type       <= op;
        req_if.device_address <= addr;
        req_if.profile_value  <= raw;
        req_if.now_ms         <= now;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        exp_res            = predict_response(op, addr, raw, now);
        expected_responses = {expected_responses, exp_res};
        requests_sent++;
    endtask

    // Stop sending and wait until every response has come back
    task automatic wait_for_responses();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_table_enable(logic value);
        wait_for_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pred_enable = value;
    endtask

    function automatic logic [ADDR_W-1:0] random_address();
        logic [15:0] hi;
        logic [31:0] lo;
        hi = 16'($urandom);
        lo = $urandom;
        return {hi, lo};
    endfunction

    // Mostly pool addresses so hits, moves and evictions are common
    task automatic send_random_request();
        int                    sel;
        op_t                   op;
        logic [ADDR_W-1:0]     addr;
        logic [RAW_PROF_W-1:0] raw;
        logic [TIME_W-1:0]     now;
        sel = $urandom_range(99);
        if (sel < 35)
            op = OP_TOUCH;
        else if (sel < 60)
            op = OP_SET;
        else if (sel < 75)
            op = OP_REMOVE;
        else
            op = OP_LOOKUP;
        if ($urandom_range(99) < 85)
            addr = addr_pool[$urandom_range(POOL_SIZE-1)];
        else
            addr = random_address();
        raw = 8'($urandom);
        if ($urandom_range(1))
            raw = 8'($urandom_range(3));
        sel = $urandom_range(19);
        if (sel == 0)
            now = '0;
        else if (sel == 1)
            now = '1;
        else
            now = $urandom;
        send_request(op, addr, raw, now);
    endtask

    // Requests while disabled are rejected and leave the table alone
    task automatic test_disabled();
        set_table_enable(1'b0);
        send_request(OP_TOUCH, 48'h0000_0000_0001, 8'h00, 32'h0000_0010);
        send_request(OP_LOOKUP, 48'h0000_0000_0001, 8'h00, 32'h0000_0011);
        wait_for_responses();
    endtask

    // Each operation once, field extremes, clamping, hit and miss paths
    task automatic test_basic_ops();
        set_table_enable(1'b1);
        send_request(OP_TOUCH, 48'h0, 8'h00, 32'h0);
        send_request(OP_TOUCH, '1, 8'hFF, '1);
        send_request(OP_SET, 48'h0, 8'hFF, 32'h1234_5678);        // clamp, kept in place
        send_request(OP_SET, '1, 8'h02, 32'h0);
        send_request(OP_SET, 48'h1234_5678_9ABC, 8'h04, 32'hCAFE_0001); // insert on miss
        send_request(OP_SET, 48'h1234_5678_9ABC, 8'h03, 32'h0);
        send_request(OP_LOOKUP, 48'h0, 8'h00, 32'h0);
        send_request(OP_LOOKUP, 48'hA5A5_5A5A_A5A5, 8'hFF, '1); // absent
        send_request(OP_TOUCH, 48'h0, 8'h00, 32'h8000_0000);      // move to front
        send_request(OP_REMOVE, 48'h5A5A_A5A5_5A5A, 8'h00, 32'h0); // absent
        send_request(OP_REMOVE, '1, 8'h00, 32'h0);                 // tail
        send_request(OP_REMOVE, 48'h0, 8'h00, 32'h0);              // head
        wait_for_responses();
    endtask

    // Fill to capacity, then evict by touch and by set on a miss
    task automatic test_fill_evict();
        while (pred_count < DEPTH)
            send_request(OP_TOUCH, random_address(), 8'($urandom), $urandom);
        send_request(OP_TOUCH, 48'hFEED_0000_0001, 8'h00, 32'h0000_0001);
        send_request(OP_SET, 48'hFEED_0000_0002, 8'h01, 32'h0000_0002);
        wait_for_responses();
    endtask

    task automatic test_random_mix(int count);
        repeat (count) send_random_request();
        wait_for_responses();
    endtask

    // Receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        hold_off_seq++;
        repeat (20) send_random_request();
        wait_for_responses();
    endtask

    task automatic test_full_rate(int count);
        no_idle = 1'b1;
        repeat (count) send_random_request();
        wait_for_responses();
        no_idle = 1'b0;
    endtask

    // Disable with a populated table, then re-enable
    task automatic test_disable_midrun(int count);
        set_table_enable(1'b0);
        repeat (count) send_random_request();
        set_table_enable(1'b1);
    endtask

    // Response ready with random idling and a counted hold-off
    initial
    begin
        int hold_left;
        int seen_seq;
        hold_left = 0;
        seen_seq  = 0;
        resp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_seq != seen_seq)
            begin
                seen_seq  = hold_off_seq;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                resp_if.ready <= 1'b0;
            end
            else if (no_idle)
                resp_if.ready <= 1'b1;
            else
                resp_if.ready <= ($urandom_range(99) >= 8);
        end
    end

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t mismatch on %s: expected %h actual %h", $time, name, exp_val, act_val);
        end
    endtask

    // Response checker: compare each beat with the oldest prediction
    always @(posedge clk)
    begin
        mdt_res_t exp_res;
        if (rst_n && resp_if.valid && resp_if.ready)
        begin
            if (expected_responses.size() == 0)
            begin
                errors++;
                $display("%0t unexpected response beat: expected none actual status %b found %b",
                         $time, resp_if.status, resp_if.found);
            end
            else
            begin
                exp_res = expected_responses.pop_front();
                responses_checked++;
                if (resp_if.evicted === 1'b1)
                    evictions_seen++;
                if (resp_if.status === 1'b1)
                    rejects_seen++;
                check_field("status", 32'(exp_res.status), 32'(resp_if.status));
                check_field("found", 32'(exp_res.found), 32'(resp_if.found));
                check_field("profile_out", 32'(exp_res.profile), 32'(resp_if.profile_out));
                check_field("last_seen_out", exp_res.last_seen, resp_if.last_seen_out);
                check_field("entry_count", 32'(exp_res.entry_count),
                            32'(resp_if.entry_count));
                check_field("evicted", 32'(exp_res.evicted), 32'(resp_if.evicted));
                check_field("changed", 32'(exp_res.changed), 32'(resp_if.changed));
            end
        end
    end

    // Main sequence
    initial
    begin
        int i;
        errors            = 0;
        requests_sent     = 0;
        responses_checked = 0;
        evictions_seen    = 0;
        rejects_seen      = 0;
        no_idle           = 1'b0;
        hold_off_seq      = 0;
        pred_enable       = 1'b0;
        pred_count        = 0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        req_if.valid          = 1'b0;
        req_if.req_type       = OP_TOUCH;
        req_if.device_address = '0;
        req_if.profile_value  = '0;
        req_if.now_ms         = '0;

        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = random_address();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled();
        test_basic_ops();
        test_fill_evict();
        test_random_mix(250);
        test_backpressure();
        test_full_rate(150);
        test_disable_midrun(10);
        test_random_mix(170);

        wait_for_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests over all four request types, enabled and disabled,",
                 requests_sent);
        $display("with %0d responses checked, %0d evictions, %0d rejects, stalls and full rate.",
                 responses_checked, evictions_seen, rejects_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
design/mdt_pkg.sv
design/mdt_if.sv
design/mdt_front.sv
design/mdt_queue.sv
design/mdt_table.sv
design/mru_device_table.sv
tb/tb_mru_device_table.sv
